// ===== rtl/touch_gesture_recognizer_assert.svh =====
// assertion macros shared by the touch gesture recognizer modules
`ifndef TOUCH_GESTURE_RECOGNIZER_ASSERT_SVH
`define TOUCH_GESTURE_RECOGNIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// condition holds at every clock edge out of reset
`define TGR_ASSERT_COMB(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define TGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TGR_ASSERT_COMB(lbl, cond, msg)
`define TGR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/tgr_pkg.sv =====
// shared types, constants and helpers of the touch gesture recognizer
package tgr_pkg;

  localparam int SLOT_COUNT = 10;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int SUM_W      = 12 + CNT_W;
  localparam int CSTEP_W    = $clog2(SUM_W + 1);

  localparam logic [1:0] FN_DOWN = 2'd0;
  localparam logic [1:0] FN_MOVE = 2'd1;
  localparam logic [1:0] FN_UP   = 2'd2;
  localparam logic [1:0] FN_PROC = 2'd3;

  localparam logic [1:0] PH_BEGAN = 2'd0;
  localparam logic [1:0] PH_MOVED = 2'd1;
  localparam logic [1:0] PH_ENDED = 2'd2;

  localparam logic [1:0] K_TAP  = 2'd0;
  localparam logic [1:0] K_PAN  = 2'd1;
  localparam logic [1:0] K_LONG = 2'd2;
  localparam logic [1:0] K_NONE = 2'd3;

  localparam logic [2:0] CFG_WIDTH      = 3'd0;
  localparam logic [2:0] CFG_HEIGHT     = 3'd1;
  localparam logic [2:0] CFG_TAP_WIN    = 3'd2;
  localparam logic [2:0] CFG_SECOND_WIN = 3'd3;
  localparam logic [2:0] CFG_PAN_MIN    = 3'd4;
  localparam logic [2:0] CFG_LONG_PRESS = 3'd5;

  typedef struct packed {
    logic [31:0] finger;
    logic [23:0] start_xy;
    logic [31:0] start_time;
    logic [23:0] now_xy;
    logic [31:0] now_time;
    logic [1:0]  phase;
  } slot_rec_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  phase;
    logic [3:0]  count;
    logic [11:0] x;
    logic [11:0] y;
  } gest_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       phase;
    logic [CNT_W-1:0] count;
    logic [11:0]      x;
    logic [11:0]      y;
  } held_t;

  typedef struct packed {
    held_t            held;
    logic             sup;
    logic             over;
    logic [CNT_W-1:0] na;
    logic [CNT_W-1:0] ne;
    slot_rec_t        act0;
    slot_rec_t        act1;
    slot_rec_t        end0;
    logic [11:0]      an_x;
    logic [11:0]      an_y;
    logic [11:0]      as_x;
    logic [11:0]      as_y;
    logic [11:0]      en_x;
    logic [11:0]      en_y;
    logic [31:0]      s_lo;
    logic [31:0]      s_hi;
    logic [31:0]      e_lo;
    logic [31:0]      e_hi;
    logic [31:0]      now;
    logic [15:0]      tap_win;
    logic [15:0]      second_win;
    logic [11:0]      pan_min;
    logic [15:0]      long_press;
  } dec_in_t;

  typedef struct packed {
    held_t      held;
    logic       sup;
    gest_t      g0;
    gest_t      g1;
    logic [1:0] n;
    logic       clr_end;
    logic       upd_act;
  } dec_out_t;

  function automatic logic [11:0] xof(input logic [23:0] xy);
    return xy[23:12];
  endfunction

  function automatic logic [11:0] yof(input logic [23:0] xy);
    return xy[11:0];
  endfunction

  function automatic logic [3:0] sat_count(input logic [CNT_W-1:0] c);
    logic [3:0] r;
    if (int'(c) > 15) r = 4'd15;
    else r = 4'(c);
    return r;
  endfunction

  function automatic logic [11:0] absdiff12(input logic [11:0] a, input logic [11:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/tgr_ram.sv =====
// slot table memory, one write and one registered read port
`include "touch_gesture_recognizer_assert.svh"
module tgr_ram (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [tgr_pkg::IDX_W-1:0] wr_addr,
  input  tgr_pkg::slot_rec_t       wr_data,
  input  logic                     rd_en,
  input  logic [tgr_pkg::IDX_W-1:0] rd_addr,
  output tgr_pkg::slot_rec_t       rd_data
);
  import tgr_pkg::*;

  slot_rec_t              mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  written;
  slot_rec_t              mem_q;
  logic                   ok_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // entries never written read as the all-zero reset record
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      ok_q    <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        ok_q <= written[rd_addr];
      end
    end
  end

  assign rd_data = ok_q ? mem_q : '0;

  `TGR_ASSERT_COMB(a_no_rw_overlap, !(wr_en && rd_en), "read and write in one cycle")

endmodule

// ===== rtl/tgr_div.sv =====
// two-lane restoring divider for the centroid sums, one bit per cycle
`include "touch_gesture_recognizer_assert.svh"
module tgr_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [tgr_pkg::SUM_W-1:0] num_x,
  input  logic [tgr_pkg::SUM_W-1:0] num_y,
  input  logic [tgr_pkg::CNT_W-1:0] den,
  output logic                     done,
  output logic [tgr_pkg::SUM_W-1:0] quo_x,
  output logic [tgr_pkg::SUM_W-1:0] quo_y
);
  import tgr_pkg::*;

  logic               busy;
  logic [CSTEP_W-1:0] cnt;
  logic [SUM_W-1:0]   nx;
  logic [SUM_W-1:0]   ny;
  logic [CNT_W-1:0]   rx;
  logic [CNT_W-1:0]   ry;
  logic [CNT_W-1:0]   dd;
  logic [CNT_W:0]     tx;
  logic [CNT_W:0]     ty;
  logic               bx;
  logic               by;

  always_comb begin
    tx = {rx, nx[SUM_W-1]};
    ty = {ry, ny[SUM_W-1]};
    bx = (tx >= {1'b0, dd});
    by = (ty >= {1'b0, dd});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= CSTEP_W'(SUM_W);
        nx   <= num_x;
        ny   <= num_y;
        rx   <= '0;
        ry   <= '0;
        dd   <= den;
      end else if (busy) begin
        nx   <= {nx[SUM_W-2:0], bx};
        ny   <= {ny[SUM_W-2:0], by};
        rx   <= bx ? CNT_W'(tx - {1'b0, dd}) : CNT_W'(tx);
        ry   <= by ? CNT_W'(ty - {1'b0, dd}) : CNT_W'(ty);
        cnt  <= cnt - CSTEP_W'(1);
        done <= (cnt == CSTEP_W'(1));
        if (cnt == CSTEP_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign quo_x = nx;
  assign quo_y = ny;

  `TGR_ASSERT_NEXT(a_done_single, done, !done, "divider done held over two cycles")

endmodule

// ===== rtl/tgr_decide.sv =====
// gesture decision on the gathered sequence summary
module tgr_decide (
  input  tgr_pkg::dec_in_t  din,
  output tgr_pkg::dec_out_t dout
);
  import tgr_pkg::*;

  logic        quick;
  logic [31:0] tap_len;
  logic [12:0] lim;
  logic        swap;
  logic [31:0] s_start;
  logic [23:0] p_xy;
  logic        pan_hit;
  logic        long_hit;
  logic        spread_ok;
  held_t       h;
  gest_t       tap2;

  function automatic gest_t mk(input held_t g);
    gest_t r;
    r.kind  = g.kind;
    r.phase = g.phase;
    r.count = sat_count(g.count);
    r.x     = g.x;
    r.y     = g.y;
    return r;
  endfunction

  always_comb begin
    // secondary finger tap: short and nearly still
    tap_len = din.end0.now_time - din.end0.start_time;
    lim     = {din.pan_min, 1'b0};
    quick   = (tap_len <= {16'd0, din.second_win})
           && ({1'b0, absdiff12(xof(din.end0.now_xy), xof(din.end0.start_xy))} <= lim)
           && ({1'b0, absdiff12(yof(din.end0.now_xy), yof(din.end0.start_xy))} <= lim);
    swap    = din.act0.start_time > din.act1.start_time;
    s_start = swap ? din.act0.start_time : din.act1.start_time;
    p_xy    = swap ? din.act1.now_xy : din.act0.now_xy;
    pan_hit = (absdiff12(din.an_x, din.as_x) >= din.pan_min)
           || (absdiff12(din.an_y, din.as_y) >= din.pan_min);
    long_hit = (din.now - din.act0.start_time) >= {16'd0, din.long_press};
    spread_ok = (din.s_hi - din.s_lo <= {16'd0, din.tap_win})
             && (din.e_hi - din.e_lo <= {16'd0, din.tap_win});
    tap2.kind  = K_TAP;
    tap2.phase = PH_ENDED;
    tap2.count = 4'd2;
    tap2.x     = xof(din.act0.now_xy);
    tap2.y     = yof(din.act0.now_xy);
  end

  always_comb begin
    h            = din.held;
    dout.g0      = '0;
    dout.g1      = '0;
    dout.n       = 2'd0;
    dout.sup     = din.sup;
    dout.clr_end = 1'b0;
    dout.upd_act = 1'b0;
    if (din.held.kind == K_PAN || din.held.kind == K_LONG) begin
      if (din.held.phase != PH_ENDED) begin
        if (din.na == din.held.count && din.ne == '0) begin
          h.x     = din.an_x;
          h.y     = din.an_y;
          h.phase = PH_MOVED;
          dout.g0 = mk(h);
          dout.n  = 2'd1;
        end else if (din.held.count == CNT_W'(1) && din.na == CNT_W'(2)
                     && din.ne == '0) begin
          if (din.now - s_start > {16'd0, din.second_win}) begin
            h.phase      = PH_ENDED;
            dout.g0      = mk(h);
            dout.n       = 2'd1;
            h.kind       = K_NONE;
            dout.upd_act = 1'b1;
          end else begin
            h.phase = PH_MOVED;
            h.x     = xof(p_xy);
            h.y     = yof(p_xy);
            dout.g0 = mk(h);
            dout.n  = 2'd1;
          end
        end else if (din.held.count == CNT_W'(1) && din.na == CNT_W'(1)
                     && din.ne == CNT_W'(1)) begin
          dout.clr_end = 1'b1;
          h.phase      = PH_MOVED;
          h.x          = xof(din.act0.now_xy);
          h.y          = yof(din.act0.now_xy);
          if (quick) begin
            dout.g0  = tap2;
            dout.g1  = mk(h);
            dout.n   = 2'd2;
            dout.sup = 1'b1;
          end else begin
            dout.g0 = mk(h);
            dout.n  = 2'd1;
          end
        end else begin
          h.phase = PH_ENDED;
          dout.g0 = mk(h);
          dout.n  = 2'd1;
        end
      end
      if (h.phase == PH_ENDED && din.over) begin
        h.kind = K_NONE;
      end
    end else begin
      if (din.na == CNT_W'(1) && din.ne == CNT_W'(1)
          && din.end0.start_time > din.act0.start_time) begin
        dout.clr_end = 1'b1;
        if (quick) begin
          dout.g0  = tap2;
          dout.n   = 2'd1;
          dout.sup = 1'b1;
        end
      end else if (din.na == '0 && din.ne != '0) begin
        if (din.ne == CNT_W'(1) && din.sup) begin
          dout.sup = 1'b0;
        end else if (spread_ok) begin
          h.x     = din.en_x;
          h.y     = din.en_y;
          h.kind  = K_TAP;
          h.phase = PH_ENDED;
          h.count = din.ne;
          dout.g0 = mk(h);
          dout.n  = 2'd1;
          h.kind  = K_NONE;
        end
      end else if (din.na != '0 && din.ne == '0) begin
        if (pan_hit || long_hit) begin
          h.kind  = pan_hit ? K_PAN : K_LONG;
          h.phase = PH_BEGAN;
          h.count = din.na;
          h.x     = din.an_x;
          h.y     = din.an_y;
          dout.g0 = mk(h);
          dout.n  = 2'd1;
        end
      end
    end
    if (din.over) begin
      dout.sup = 1'b0;
    end
    dout.held = h;
  end

endmodule

// ===== rtl/touch_gesture_recognizer.sv =====
// top level: slot table sequencer, configuration registers and result queue
//
// channel  | dir | handshake            | payload
// in       | in  | in_valid / in_ready  | func, finger_id, x_frac, y_frac, time_ms
// out      | out | out_valid / out_ready| gesture_kind/phase, finger_count, pos_x/y, last
// cfg      | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// finger events read slots until the id matches (at most 10), then write at most one slot
// process beats walk the slot memory one slot at a time: one pass for the earliest
// start, one more per end-search restart, one split pass, then up to three centroid
// divides, a decide step, an active slot rewrite if needed, one beat per result
// reset clears slot valid flags and held gesture, loads default config; no clearing pass
// in_ready stays low from accept until the beat is done, after its last result beat if any
`include "touch_gesture_recognizer_assert.svh"
module touch_gesture_recognizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] finger_id,
  input  logic [16:0] x_frac,
  input  logic [16:0] y_frac,
  input  logic [31:0] time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  gesture_kind,
  output logic [1:0]  gesture_phase,
  output logic [3:0]  finger_count,
  output logic [11:0] pos_x,
  output logic [11:0] pos_y,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tgr_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE  = 18'b000000000000000001,
    S_CONV  = 18'b000000000000000010,
    S_ERD   = 18'b000000000000000100,
    S_ECHK  = 18'b000000000000001000,
    S_EWR   = 18'b000000000000010000,
    S_FRD   = 18'b000000000000100000,
    S_FCHK  = 18'b000000000001000000,
    S_FEND  = 18'b000000000010000000,
    S_XRD   = 18'b000000000100000000,
    S_XCHK  = 18'b000000001000000000,
    S_SINIT = 18'b000000010000000000,
    S_SRD   = 18'b000000100000000000,
    S_SCHK  = 18'b000001000000000000,
    S_DIV   = 18'b000010000000000000,
    S_DEC   = 18'b000100000000000000,
    S_UP0   = 18'b001000000000000000,
    S_UP1   = 18'b010000000000000000,
    S_OUT   = 18'b100000000000000000
  } state_t;

  state_t state;

  // configuration
  logic [11:0] cfg_w;
  logic [11:0] cfg_h;
  logic [15:0] tap_win;
  logic [15:0] second_win;
  logic [11:0] pan_min;
  logic [15:0] long_press;

  // accepted beat
  logic [1:0]  func_q;
  logic [31:0] id_q;
  logic [16:0] xf_q;
  logic [16:0] yf_q;
  logic [31:0] t_q;
  logic [23:0] xy_q;

  logic [IDX_W-1:0]      idx;
  logic                  idx_last;
  logic [SLOT_COUNT-1:0] used;
  logic                  match;
  logic [IDX_W-1:0]      midx;
  slot_rec_t             mrec;

  logic        found;
  logic [31:0] seq_start;
  logic [1:0]  fphase;
  logic [31:0] fnow;
  logic [31:0] seq_end;
  logic        over;

  logic [CNT_W-1:0] na;
  logic [CNT_W-1:0] ne;
  slot_rec_t        act0;
  slot_rec_t        act1;
  slot_rec_t        end0;
  logic [IDX_W-1:0] act0_idx;
  logic [IDX_W-1:0] act1_idx;
  logic [IDX_W-1:0] end0_idx;
  logic [SUM_W-1:0] an_sx;
  logic [SUM_W-1:0] an_sy;
  logic [SUM_W-1:0] as_sx;
  logic [SUM_W-1:0] as_sy;
  logic [SUM_W-1:0] en_sx;
  logic [SUM_W-1:0] en_sy;
  logic [31:0]      s_lo;
  logic [31:0]      s_hi;
  logic [31:0]      e_lo;
  logic [31:0]      e_hi;
  logic [11:0]      an_x;
  logic [11:0]      an_y;
  logic [11:0]      as_x;
  logic [11:0]      as_y;
  logic [11:0]      en_x;
  logic [11:0]      en_y;

  logic [1:0] op;
  logic       div_run;
  held_t      held;
  logic       sup;
  gest_t      outq0;
  gest_t      outq1;
  logic [1:0] n_out;
  logic       oi;

  // memory and divider hookup
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_rec_t        wr_data;
  logic             rd_en;
  slot_rec_t        rec;
  logic             div_start;
  logic [SUM_W-1:0] div_nx;
  logic [SUM_W-1:0] div_ny;
  logic [CNT_W-1:0] div_den;
  logic             div_done;
  logic [SUM_W-1:0] quo_x;
  logic [SUM_W-1:0] quo_y;

  logic             free_any;
  logic [IDX_W-1:0] free_idx;
  logic [28:0]      prod_x;
  logic [28:0]      prod_y;
  logic [11:0]      px_x;
  logic [11:0]      px_y;
  logic             in_seq_start;
  logic             in_seq_now;
  dec_in_t          din;
  dec_out_t         dout;
  gest_t            cur;

  tgr_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rec)
  );

  tgr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_x (div_nx),
    .num_y (div_ny),
    .den   (div_den),
    .done  (div_done),
    .quo_x (quo_x),
    .quo_y (quo_y)
  );

  tgr_decide u_decide (
    .din  (din),
    .dout (dout)
  );

  assign idx_last = (idx == IDX_W'(SLOT_COUNT - 1));

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // pixel = floor(frac * size / 65536), saturated to 12 bits
  always_comb begin
    prod_x = 29'(xf_q) * 29'(cfg_w);
    prod_y = 29'(yf_q) * 29'(cfg_h);
    px_x   = prod_x[28] ? 12'hFFF : prod_x[27:16];
    px_y   = prod_y[28] ? 12'hFFF : prod_y[27:16];
  end

  assign in_seq_start = (rec.start_time >= seq_start) && (rec.start_time <= seq_end);
  assign in_seq_now   = (rec.now_time >= seq_start) && (rec.now_time <= seq_end);

  assign rd_en = (state == S_ERD) || (state == S_FRD) || (state == S_XRD)
              || (state == S_SRD);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      S_EWR: begin
        if (func_q == FN_DOWN) begin
          wr_en   = match || free_any;
          wr_addr = match ? midx : free_idx;
          wr_data = '{finger: id_q, start_xy: xy_q, start_time: t_q,
                      now_xy: xy_q, now_time: t_q, phase: PH_BEGAN};
        end else begin
          wr_en          = match;
          wr_addr        = midx;
          wr_data        = mrec;
          wr_data.now_xy   = xy_q;
          wr_data.now_time = t_q;
          wr_data.phase    = (func_q == FN_MOVE) ? PH_MOVED : PH_ENDED;
        end
      end
      S_UP0: begin
        wr_en              = 1'b1;
        wr_addr            = act0_idx;
        wr_data            = act0;
        wr_data.start_xy   = act0.now_xy;
        wr_data.start_time = t_q;
      end
      S_UP1: begin
        wr_en              = 1'b1;
        wr_addr            = act1_idx;
        wr_data            = act1;
        wr_data.start_xy   = act1.now_xy;
        wr_data.start_time = t_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    div_nx  = an_sx;
    div_ny  = an_sy;
    div_den = na;
    case (op)
      2'd1: begin
        div_nx = as_sx;
        div_ny = as_sy;
      end
      2'd2: begin
        div_nx  = en_sx;
        div_ny  = en_sy;
        div_den = ne;
      end
      default: begin
        div_nx = an_sx;
      end
    endcase
    div_start = (state == S_DIV) && !div_run && (op != 2'd3) && (div_den != '0);
  end

  always_comb begin
    din.held       = held;
    din.sup        = sup;
    din.over       = over;
    din.na         = na;
    din.ne         = ne;
    din.act0       = act0;
    din.act1       = act1;
    din.end0       = end0;
    din.an_x       = an_x;
    din.an_y       = an_y;
    din.as_x       = as_x;
    din.as_y       = as_y;
    din.en_x       = en_x;
    din.en_y       = en_y;
    din.s_lo       = s_lo;
    din.s_hi       = s_hi;
    din.e_lo       = e_lo;
    din.e_hi       = e_hi;
    din.now        = t_q;
    din.tap_win    = tap_win;
    din.second_win = second_win;
    din.pan_min    = pan_min;
    din.long_press = long_press;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w      <= 12'd640;
      cfg_h      <= 12'd480;
      tap_win    <= 16'd75;
      second_win <= 16'd250;
      pan_min    <= 12'd4;
      long_press <= 16'd500;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:      cfg_w      <= cfg_data[11:0];
        CFG_HEIGHT:     cfg_h      <= cfg_data[11:0];
        CFG_TAP_WIN:    tap_win    <= cfg_data;
        CFG_SECOND_WIN: second_win <= cfg_data;
        CFG_PAN_MIN:    pan_min    <= cfg_data[11:0];
        CFG_LONG_PRESS: long_press <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      used    <= '0;
      held    <= '{kind: K_NONE, phase: PH_BEGAN, count: '0, x: '0, y: '0};
      sup     <= 1'b0;
      div_run <= 1'b0;
      op      <= '0;
      oi      <= 1'b0;
      n_out   <= '0;
      match   <= 1'b0;
      found   <= 1'b0;
      over    <= 1'b0;
      idx     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q <= func;
            id_q   <= finger_id;
            xf_q   <= x_frac;
            yf_q   <= y_frac;
            t_q    <= time_ms;
            state  <= S_CONV;
          end
        end
        S_CONV: begin
          xy_q  <= {px_x, px_y};
          idx   <= '0;
          match <= 1'b0;
          found <= 1'b0;
          state <= (func_q == FN_PROC) ? S_FRD : S_ERD;
        end
        S_ERD: state <= S_ECHK;
        S_ECHK: begin
          if (rec.finger == id_q) begin
            match <= 1'b1;
            midx  <= idx;
            mrec  <= rec;
            state <= S_EWR;
          end else if (idx_last) begin
            state <= S_EWR;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_ERD;
          end
        end
        S_EWR: begin
          if (func_q == FN_DOWN && (match || free_any)) begin
            used[match ? midx : free_idx] <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (used[idx] && (!found || rec.start_time < seq_start)) begin
            found     <= 1'b1;
            seq_start <= rec.start_time;
            fphase    <= rec.phase;
            fnow      <= rec.now_time;
          end
          if (idx_last) begin
            state <= S_FEND;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_FRD;
          end
        end
        S_FEND: begin
          idx <= '0;
          if (!found) begin
            state <= S_IDLE;
          end else if (fphase == PH_ENDED) begin
            over    <= 1'b1;
            seq_end <= fnow;
            state   <= S_XRD;
          end else begin
            over    <= 1'b0;
            seq_end <= '1;
            state   <= S_SINIT;
          end
        end
        S_XRD: state <= S_XCHK;
        S_XCHK: begin
          // sequence is open while any finger started inside it is still down
          if (used[idx] && in_seq_start && rec.phase == PH_ENDED
              && seq_end < rec.now_time) begin
            seq_end <= rec.now_time;
            idx     <= '0;
            state   <= S_XRD;
          end else if (used[idx] && in_seq_start && rec.phase != PH_ENDED) begin
            over    <= 1'b0;
            seq_end <= '1;
            state   <= S_SINIT;
          end else if (idx_last) begin
            state <= S_SINIT;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_XRD;
          end
        end
        S_SINIT: begin
          idx   <= '0;
          na    <= '0;
          ne    <= '0;
          an_sx <= '0;
          an_sy <= '0;
          as_sx <= '0;
          as_sy <= '0;
          en_sx <= '0;
          en_sy <= '0;
          s_lo  <= '1;
          s_hi  <= '0;
          e_lo  <= '1;
          e_hi  <= '0;
          state <= S_SRD;
        end
        S_SRD: state <= S_SCHK;
        S_SCHK: begin
          if (used[idx] && in_seq_now) begin
            if (rec.phase == PH_ENDED) begin
              if (ne == '0) begin
                end0     <= rec;
                end0_idx <= idx;
              end
              ne    <= ne + CNT_W'(1);
              en_sx <= en_sx + SUM_W'(xof(rec.now_xy));
              en_sy <= en_sy + SUM_W'(yof(rec.now_xy));
              if (rec.start_time < s_lo) s_lo <= rec.start_time;
              if (rec.start_time > s_hi) s_hi <= rec.start_time;
              if (rec.now_time < e_lo) e_lo <= rec.now_time;
              if (rec.now_time > e_hi) e_hi <= rec.now_time;
            end else begin
              if (na == '0) begin
                act0     <= rec;
                act0_idx <= idx;
              end
              if (na == CNT_W'(1)) begin
                act1     <= rec;
                act1_idx <= idx;
              end
              na    <= na + CNT_W'(1);
              an_sx <= an_sx + SUM_W'(xof(rec.now_xy));
              an_sy <= an_sy + SUM_W'(yof(rec.now_xy));
              as_sx <= as_sx + SUM_W'(xof(rec.start_xy));
              as_sy <= as_sy + SUM_W'(yof(rec.start_xy));
            end
            if (over) used[idx] <= 1'b0;
          end
          if (idx_last) begin
            op      <= '0;
            div_run <= 1'b0;
            state   <= S_DIV;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= S_SRD;
          end
        end
        S_DIV: begin
          if (op == 2'd3) begin
            state <= S_DEC;
          end else if (!div_run) begin
            if (div_den == '0) op <= op + 2'd1;
            else div_run <= 1'b1;
          end else if (div_done) begin
            case (op)
              2'd0: begin
                an_x <= quo_x[11:0];
                an_y <= quo_y[11:0];
              end
              2'd1: begin
                as_x <= quo_x[11:0];
                as_y <= quo_y[11:0];
              end
              default: begin
                en_x <= quo_x[11:0];
                en_y <= quo_y[11:0];
              end
            endcase
            op      <= op + 2'd1;
            div_run <= 1'b0;
          end
        end
        S_DEC: begin
          held  <= dout.held;
          sup   <= dout.sup;
          outq0 <= dout.g0;
          outq1 <= dout.g1;
          n_out <= dout.n;
          oi    <= 1'b0;
          if (dout.clr_end) used[end0_idx] <= 1'b0;
          if (dout.upd_act) state <= S_UP0;
          else if (dout.n != 2'd0) state <= S_OUT;
          else state <= S_IDLE;
        end
        S_UP0: state <= S_UP1;
        S_UP1: state <= (n_out != 2'd0) ? S_OUT : S_IDLE;
        S_OUT: begin
          if (out_ready) begin
            if (last) state <= S_IDLE;
            else oi <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state == S_OUT);
  assign cur       = oi ? outq1 : outq0;

  assign gesture_kind  = cur.kind;
  assign gesture_phase = cur.phase;
  assign finger_count  = cur.count;
  assign pos_x         = cur.x;
  assign pos_y         = cur.y;
  assign last          = (n_out == 2'd2) ? oi : 1'b1;

  `TGR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  `TGR_ASSERT_COMB(a_out_index, !out_valid || n_out == 2'd2 || (n_out == 2'd1 && !oi),
                   "result index beyond queue fill")
  `TGR_ASSERT_NEXT(a_last_ends_item, out_valid && out_ready && last, !out_valid,
                   "result shown after last beat")

endmodule
